/* rtl/cts_pkg.sv */
// Package for the COO to CSR sorter: widths, status codes, config indexes.
// No dependencies.
package cts_pkg;
   localparam int MaxEntries = 1024;
   localparam int MaxDim = 1024;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 11;

   localparam logic [CsrIdxW-1:0] CSR_NUM_ROWS = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_NUM_COLS = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_COL_MAJOR = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_UNSORTED = 2'd3;

   localparam int ReqDataW = 104;  // row, col, value, read_index, pad
   localparam int RspDataW = 112;
endpackage

/* rtl/coo_to_csr_sorter_unit.sv */
// Top level of the COO to CSR sorter: load store, insertion sort engine,
// pointer builder and read port. Depends on cts_pkg.
//
//  channel | dir | contents
//  req_    | in  | tuser=func, tlast=last_entry, tdata=row,col,value,read_index
//  rsp_    | out | tdata=status,out_row,out_col,out_value,group_start,entry_count
//  csr_    | in  | we, index, data
//
// A load is answered in the cycle after its transfer; loads stream at one per
// cycle while the response side keeps up. A read steps through an address
// state, a registered memory read and a response state. A last entry adds
// the sort on one compare unit, then the pointer build. Reset is synchronous;
// the stores keep their contents.
// The request side is not ready while a read, sort or pointer build is in
// flight, or while a response waits and is not taken in the same cycle.
module coo_to_csr_sorter_unit
   import cts_pkg::*;
#(
   parameter int MAX_ENTRIES = MaxEntries,
   parameter int MAX_DIM = MaxDim
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // [10:0] row_index, [21:11] col_index, [85:22] entry_value,
   // [96:86] read_index, zero padded
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                req_tuser,   // func
   input  logic                req_tlast,   // last_entry
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [1:0] status, [11:2] out_row, [21:12] out_col, [85:22] out_value,
   // [96:86] group_start, [107:97] entry_count, zero padded
   output logic [RspDataW-1:0] rsp_tdata,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_data
);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int RW = $clog2(MAX_DIM);
   localparam int EW = 2 * RW + 64;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_RDW, S_SRD, S_SKEY, S_SCMP, S_SPUT, S_PTR, S_PTRW
   } state_type;

   state_type state_ff;
   logic [10:0] rows_ff, cols_ff;
   logic colmaj_ff;
   logic [CW-1:0] cnt_ff;
   logic sorted_ff;
   logic [DW-1:0] sdim_ff;

   // entry memory: {row, col, value}
   logic [EW-1:0] mem [MAX_ENTRIES];
   logic [CW-1:0] ptr_mem [MAX_DIM + 1];
   logic [EW-1:0] rdata_ff;
   logic [CW-1:0] prdata_ff;

   logic [CW-1:0] i_ff, j_ff;   // insertion sort indexes
   logic [EW-1:0] key_ff;        // element being inserted
   logic [CW-1:0] p_ff;          // pointer build position
   logic [DW-1:0] k_ff;          // pointer index
   logic [10:0] rd_ff;
   logic [RspDataW-1:0] rsp_ff;
   logic rsp_v_ff;

   logic [10:0] ri, ci, rdi;
   logic [63:0] val;
   logic [10:0] er, ec;
   logic acc, load_bad, load_full;
   logic [CW-1:0] n_base, cnt_in;
   logic mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [EW-1:0] mem_wdata;
   logic ptr_we;
   logic [DW-1:0] ptr_waddr, ptr_raddr;
   logic shift, ptr_adv, eok, pok, rsp_load;
   logic [RspDataW-1:0] rsp_in;

   function automatic logic [2*RW-1:0] key_of(input logic [EW-1:0] e,
                                              input logic cm);
      key_of = cm ? {e[63+RW -: RW], e[EW-1 -: RW]} : e[EW-1 -: 2*RW];
   endfunction

   function automatic logic [RW-1:0] major_of(input logic [EW-1:0] e,
                                              input logic cm);
      major_of = cm ? e[63+RW -: RW] : e[EW-1 -: RW];
   endfunction

   assign ri = req_tdata[10:0];
   assign ci = req_tdata[21:11];
   assign val = req_tdata[85:22];
   assign rdi = req_tdata[96:86];
   assign er = (rows_ff == 11'd0) ? 11'd1 :
      ({21'd0, rows_ff} > 32'(MAX_DIM) ? 11'(MAX_DIM) : rows_ff);
   assign ec = (cols_ff == 11'd0) ? 11'd1 :
      ({21'd0, cols_ff} > 32'(MAX_DIM) ? 11'(MAX_DIM) : cols_ff);

   assign req_tready = !reset && (state_ff == S_IDLE) && (!rsp_v_ff || rsp_tready);
   assign acc = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata = rsp_ff;

   // a load after a finished sort starts a new set
   assign n_base = sorted_ff ? '0 : cnt_ff;
   assign load_bad = ri == 11'd0 || ri > er || ci == 11'd0 || ci > ec;
   assign load_full = 32'(n_base) >= MAX_ENTRIES;
   assign eok = 32'(rd_ff) < 32'(cnt_ff);
   assign pok = 32'(rd_ff) <= 32'(sdim_ff);
   assign shift = key_of(rdata_ff, colmaj_ff) > key_of(key_ff, colmaj_ff);
   assign ptr_adv = (32'(p_ff) < 32'(cnt_ff)) &&
      (32'(major_of(rdata_ff, colmaj_ff)) < 32'(k_ff));

   always_comb begin
      mem_we = 1'b0;
      mem_waddr = '0;
      mem_wdata = key_ff;
      mem_raddr = '0;
      ptr_we = 1'b0;
      ptr_waddr = k_ff;
      ptr_raddr = pok ? DW'(rd_ff) : '0;
      cnt_in = cnt_ff;
      rsp_load = 1'b0;
      rsp_in = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc && !req_tuser) begin
               cnt_in = n_base;
               rsp_load = 1'b1;
               if (!load_bad && !load_full) begin
                  mem_we = 1'b1;
                  mem_waddr = n_base[AW-1:0];
                  mem_wdata = {RW'(ri - 11'd1), RW'(ci - 11'd1), val};
                  cnt_in = n_base + CW'(1);
               end
               rsp_in = {4'd0, 11'(cnt_in), 95'd0,
                  load_bad ? ST_RANGE : (load_full ? ST_OVERFLOW : ST_OK)};
            end else if (acc && !sorted_ff) begin
               rsp_load = 1'b1;
               rsp_in = {4'd0, 11'(cnt_ff), 95'd0, ST_UNSORTED};
            end
         end
         S_RD: mem_raddr = AW'(rd_ff);
         S_RDW: begin
            rsp_load = 1'b1;
            rsp_in = {4'd0, 11'(cnt_ff),
               pok ? 11'(prdata_ff) : 11'(cnt_ff),
               eok ? rdata_ff[63:0] : 64'd0,
               eok ? 10'(rdata_ff[63+RW -: RW]) : 10'd0,
               eok ? 10'(rdata_ff[EW-1 -: RW]) : 10'd0,
               (!eok && !pok) ? ST_RANGE : ST_OK};
         end
         S_SRD: mem_raddr = AW'(i_ff);
         S_SKEY: mem_raddr = AW'(j_ff - CW'(1));
         // move the larger entry up, or drop the key into place
         S_SCMP: begin
            mem_we = 1'b1;
            mem_waddr = AW'(j_ff);
            mem_wdata = shift ? rdata_ff : key_ff;
            mem_raddr = AW'(j_ff - CW'(2));
         end
         S_SPUT: begin
            mem_we = 1'b1;
            mem_waddr = AW'(j_ff);
         end
         S_PTR: mem_raddr = AW'(p_ff);
         S_PTRW: begin
            mem_raddr = ptr_adv ? AW'(p_ff + CW'(1)) : AW'(p_ff);
            ptr_we = !ptr_adv;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[mem_raddr];
      if (ptr_we) ptr_mem[ptr_waddr] <= p_ff;
      prdata_ff <= ptr_mem[ptr_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rows_ff <= 11'd1024;
         cols_ff <= 11'd1024;
         colmaj_ff <= 1'b0;
         cnt_ff <= '0;
         sorted_ff <= 1'b0;
         sdim_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_ROWS: rows_ff <= csr_data;
               CSR_NUM_COLS: cols_ff <= csr_data;
               CSR_COL_MAJOR: colmaj_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (rsp_load) rsp_v_ff <= 1'b1;
         else if (rsp_tready) rsp_v_ff <= 1'b0;
         rsp_ff <= rsp_in;
         cnt_ff <= cnt_in;
         case (state_ff)
            S_IDLE: begin
               if (acc && req_tuser) begin
                  rd_ff <= rdi;
                  if (sorted_ff) state_ff <= S_RD;
               end else if (acc) begin
                  sorted_ff <= 1'b0;
                  if (req_tlast) begin
                     sdim_ff <= DW'(colmaj_ff ? ec : er);
                     i_ff <= CW'(1);
                     state_ff <= S_SRD;
                  end
               end
            end
            S_RD: state_ff <= S_RDW;
            S_RDW: state_ff <= S_IDLE;
            // insertion sort: fetch element i, then walk j down
            S_SRD: begin
               if (i_ff >= cnt_ff) begin
                  p_ff <= '0;
                  k_ff <= '0;
                  state_ff <= S_PTR;
               end else begin
                  j_ff <= i_ff;
                  state_ff <= S_SKEY;
               end
            end
            S_SKEY: begin
               key_ff <= rdata_ff;
               state_ff <= S_SCMP;
            end
            S_SCMP: begin
               if (!shift) begin
                  i_ff <= i_ff + CW'(1);
                  state_ff <= S_SRD;
               end else begin
                  j_ff <= j_ff - CW'(1);
                  if (j_ff == CW'(1)) state_ff <= S_SPUT;
               end
            end
            S_SPUT: begin
               i_ff <= i_ff + CW'(1);
               state_ff <= S_SRD;
            end
            S_PTR: state_ff <= S_PTRW;
            // advance p past smaller major keys, else write pointer k
            S_PTRW: begin
               if (ptr_adv) begin
                  p_ff <= p_ff + CW'(1);
               end else if (k_ff == sdim_ff) begin
                  sorted_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  k_ff <= k_ff + DW'(1);
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata));
   assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= MAX_ENTRIES);
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid || rsp_tready);
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RspDataW-1 -: 4] == 4'd0);
endmodule
